/* hw/rtl/sds_ie_pkg.sv */
// Types and constants shared by the SDS message element parser.
`default_nettype none
package sds_ie_pkg;

	// parse phase, one-hot
	typedef enum logic [6:0] {
		PH_AWAIT  = 7'b0000001,
		PH_FIXED  = 7'b0000010,
		PH_ELEMS  = 7'b0000100,
		PH_STOP   = 7'b0001000,
		PH_DCOUNT = 7'b0010000,
		PH_DELEMS = 7'b0100000,
		PH_REJECT = 7'b1000000
	} phase_t;

	typedef enum logic [1:0] {
		V_SDS   = 2'd0,
		V_FD    = 2'd1,
		V_NOTIF = 2'd2,
		V_DATA  = 2'd3
	} variant_t;

	typedef enum logic [1:0] {
		STR_NONE = 2'd0,
		STR_OPEN = 2'd1,
		STR_DONE = 2'd2
	} str_state_t;

	// element header step
	localparam logic [1:0] HDR_CODE   = 2'd0;
	localparam logic [1:0] HDR_LEN_HI = 2'd1;
	localparam logic [1:0] HDR_LEN_LO = 2'd2;
	localparam logic [1:0] HDR_BODY   = 2'd3;

	// result word kinds
	localparam logic [1:0] RK_CONV    = 2'd0;
	localparam logic [1:0] RK_MSG     = 2'd1;
	localparam logic [1:0] RK_STRING  = 2'd2;
	localparam logic [1:0] RK_SUMMARY = 2'd3;

	// config register indexes
	localparam logic [1:0] CFG_TYPE_SDS   = 2'd0;
	localparam logic [1:0] CFG_TYPE_FD    = 2'd1;
	localparam logic [1:0] CFG_TYPE_DATA  = 2'd2;
	localparam logic [1:0] CFG_TYPE_NOTIF = 2'd3;

	localparam logic [7:0] TYPE_MASK     = 8'h3F;
	localparam logic [3:0] IE_DISP_SDS   = 4'h8;  // high nibble, TV disposition (SDS)
	localparam logic [3:0] IE_DISP_FD    = 4'h9;  // high nibble, TV disposition (FD)
	localparam logic [3:0] IE_MAND_DL    = 4'hA;  // high nibble, mandatory download
	localparam logic [7:0] IE_FIX16      = 8'h21;
	localparam logic [7:0] IE_FIX1       = 8'h22;
	localparam logic [7:0] IE_SDS_TLVE   = 8'h7D;
	localparam logic [7:0] IE_PAYLOAD    = 8'h78;
	localparam logic [7:0] IE_META       = 8'h79;
	localparam logic [7:0] IE_APP_DATA   = 8'h7A;
	localparam logic [7:0] PL_FILEURL    = 8'h04;
	localparam logic [7:0] PL_TEXT       = 8'h01;

	// fixed layout offsets, counted from the type byte (shifted by one for the notif octet)
	localparam int TIME_FIRST = 1;
	localparam int TIME_LAST  = 5;
	localparam int CONV_FIRST = 6;
	localparam int CONV_LAST  = 21;
	localparam int MSG_FIRST  = 22;
	localparam int MSG_LAST   = 37;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [7:0]  out_byte;
		logic        string_is_url;
		logic        accepted;
		logic [5:0]  message_type;
		logic [39:0] sent_time;
		logic [3:0]  disposition;
		logic        disposition_present;
		logic [7:0]  notification_type;
		logic [23:0] payload_size;
		logic        string_complete;
		logic        last;
	} result_t;

endpackage
`default_nettype wire

/* hw/rtl/sds_message_ie_parser.sv */
// Top level of the SDS message element parser: byte stage, parse state, result queue.
`default_nettype none
// The parser takes one message byte per word on the input channel and sustains one
// byte per clock while the result queue has room. Each byte is first captured in an
// input register; from there short logic updates the parse state and writes its
// result words (at most two: an ID or string byte, plus the summary when last_byte
// is set) into a four-word result queue. The queue drains one word per cycle while
// the sink is ready; the input stalls only while the queue has fewer than two free
// slots, which happens only when the sink holds off or message-ending ID or string
// bytes, which make two words each, follow each other too closely. The type byte and
// kind select SDS signalling, FD signalling, SDS notification or data payload by the
// four type registers; a set kind picks data payload, otherwise the first match in
// the order SDS, FD, notification wins. Sent time and notification type are
// committed once the fixed part is complete; the element walk stops at the first
// unknown signalling element. Payload size and text-taken persist across messages
// until reset. Type registers may be written at any time but only take effect
// consistently while no message is in flight.
module sds_message_ie_parser #(
	parameter int POSITION_BITS = 24,
	parameter int SIZE_BITS     = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// config write
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [5:0]  cfg_data,
	// byte input
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	// result output
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       result_kind,
	output logic [7:0]       out_byte,
	output logic             string_is_url,
	output logic             accepted,
	output logic [5:0]       message_type,
	output logic [39:0]      sent_time,
	output logic [3:0]       disposition,
	output logic             disposition_present,
	output logic [7:0]       notification_type,
	output logic [23:0]      payload_size,
	output logic             string_complete,
	output logic             last
);
	import sds_ie_pkg::*;

	// ---------------- config registers ----------------
	logic [5:0] type_sds_q, type_fd_q, type_data_q, type_notif_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_sds_q   <= 6'd1;
			type_fd_q    <= 6'd2;
			type_data_q  <= 6'd3;
			type_notif_q <= 6'd5;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TYPE_SDS:   type_sds_q   <= cfg_data;
				CFG_TYPE_FD:    type_fd_q    <= cfg_data;
				CFG_TYPE_DATA:  type_data_q  <= cfg_data;
				CFG_TYPE_NOTIF: type_notif_q <= cfg_data;
				default:        type_sds_q   <= type_sds_q;
			endcase
		end
	end

	// ---------------- input register ----------------
	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       proc;       // byte in s1 is parsed this cycle
	logic [2:0] count_q;    // result queue fill

	assign proc     = valid_s1 && (count_q <= 3'd2);
	assign in_ready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1 <= kind;
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// ---------------- parse state ----------------
	phase_t                   phase_q, phase_d;
	variant_t                 variant_q, variant_d;
	str_state_t               str_q, str_d;
	logic [POSITION_BITS-1:0] pos_q, pos_d, rel;
	logic [7:0]               code_q, code_d;
	logic [1:0]               hdr_q, hdr_d;
	logic [15:0]              len_q, len_d;
	logic [15:0]              rem_q, rem_d;
	logic [39:0]              tacc_q, tacc_d, twork_q, twork_d;
	logic [5:0]               type_q, type_d;
	logic [3:0]               disp_q, disp_d;
	logic                     dseen_q, dseen_d;
	logic [7:0]               notif_q, notif_d, nwork_q, nwork_d;
	logic [SIZE_BITS-1:0]     size_q, size_d;
	logic [SIZE_BITS:0]       size_sum;
	logic                     text_q, text_d;

	logic        el_done;
	logic        add_en;
	logic [15:0] add_val;
	logic        emit_a;
	result_t     res_a, res_sum;
	logic        is_notif;
	logic [SIZE_BITS+23:0] size_ext;

	assign is_notif = (variant_q == V_NOTIF);
	assign rel      = pos_q - POSITION_BITS'(is_notif);

	always_comb begin
		phase_d   = phase_q;
		variant_d = variant_q;
		str_d     = str_q;
		code_d    = code_q;
		hdr_d     = hdr_q;
		len_d     = len_q;
		rem_d     = rem_q;
		tacc_d    = tacc_q;
		twork_d   = twork_q;
		type_d    = type_q;
		disp_d    = disp_q;
		dseen_d   = dseen_q;
		notif_d   = notif_q;
		nwork_d   = nwork_q;
		size_d    = size_q;
		text_d    = text_q;
		el_done   = 1'b0;
		add_en    = 1'b0;
		add_val   = 16'd0;
		size_sum  = '0;
		emit_a    = 1'b0;
		res_a     = '0;
		res_a.out_byte = byte_s1;

		unique case (phase_q)
			PH_AWAIT: begin
				type_d  = byte_s1[5:0] & TYPE_MASK[5:0];
				twork_d = '0;
				nwork_d = '0;
				if (!kind_s1) begin
					phase_d = PH_FIXED;
					if (type_d == type_sds_q) begin
						variant_d = V_SDS;
					end else if (type_d == type_fd_q) begin
						variant_d = V_FD;
					end else if (type_d == type_notif_q) begin
						variant_d = V_NOTIF;
					end else begin
						phase_d = PH_REJECT;
					end
				end else begin
					variant_d = V_DATA;
					phase_d   = (type_d == type_data_q) ? PH_DCOUNT : PH_REJECT;
				end
			end
			PH_FIXED: begin
				if (is_notif && pos_q == POSITION_BITS'(1)) begin
					nwork_d = byte_s1;
				end
				if (rel >= POSITION_BITS'(TIME_FIRST) && rel <= POSITION_BITS'(TIME_LAST)) begin
					twork_d = {twork_q[31:0], byte_s1};
				end
				if (rel >= POSITION_BITS'(CONV_FIRST) && rel <= POSITION_BITS'(CONV_LAST)) begin
					emit_a            = 1'b1;
					res_a.result_kind = RK_CONV;
				end else if (rel >= POSITION_BITS'(MSG_FIRST)
						&& rel <= POSITION_BITS'(MSG_LAST)) begin
					emit_a            = 1'b1;
					res_a.result_kind = RK_MSG;
				end
				if (rel == POSITION_BITS'(MSG_LAST)) begin
					tacc_d = twork_d;
					if (is_notif) begin
						notif_d = nwork_d;
						phase_d = PH_STOP;
					end else begin
						phase_d = PH_ELEMS;
					end
					hdr_d = HDR_CODE;
				end
			end
			PH_DCOUNT: begin
				phase_d = PH_DELEMS;
				hdr_d   = HDR_CODE;
			end
			PH_ELEMS, PH_DELEMS: begin
				unique case (hdr_q)
					HDR_CODE: begin
						code_d = byte_s1;
						len_d  = '0;
						if (variant_q == V_DATA) begin
							hdr_d = HDR_LEN_HI;
						end else if ((variant_q == V_SDS && byte_s1[7:4] == IE_DISP_SDS)
								|| (variant_q == V_FD && byte_s1[7:4] == IE_DISP_FD)) begin
							disp_d  = byte_s1[3:0];
							dseen_d = 1'b1;
						end else if (variant_q == V_FD && byte_s1[7:4] == IE_MAND_DL) begin
							hdr_d = HDR_CODE;  // single-octet element
						end else if (byte_s1 == IE_FIX16) begin
							rem_d = 16'd16;
							hdr_d = HDR_BODY;
						end else if (byte_s1 == IE_FIX1) begin
							rem_d = 16'd1;
							hdr_d = HDR_BODY;
						end else if ((variant_q == V_SDS && byte_s1 == IE_SDS_TLVE)
								|| (variant_q == V_FD
								&& (byte_s1 == IE_PAYLOAD || byte_s1 == IE_META))) begin
							hdr_d = HDR_LEN_HI;
						end else begin
							phase_d = PH_STOP;  // unknown element ends the walk
						end
					end
					HDR_LEN_HI: begin
						len_d = {byte_s1, 8'd0};
						hdr_d = HDR_LEN_LO;
					end
					HDR_LEN_LO: begin
						len_d = {len_q[15:8], byte_s1};
						rem_d = len_d;
						if (len_d == 16'd0) begin
							el_done = 1'b1;
						end else begin
							hdr_d = HDR_BODY;
						end
					end
					HDR_BODY: begin
						if (code_q == IE_PAYLOAD && rem_q == len_q) begin
							// payload type octet opens a string
							if ((variant_q == V_FD && byte_s1 == PL_FILEURL)
									|| (variant_q == V_DATA && byte_s1 == PL_TEXT
									&& !text_q)) begin
								str_d = (len_q == 16'd1) ? STR_DONE : STR_OPEN;
							end
						end else if (str_q == STR_OPEN) begin
							emit_a              = 1'b1;
							res_a.result_kind   = RK_STRING;
							res_a.string_is_url = (variant_q == V_FD);
							if (rem_q == 16'd1) begin
								str_d                 = STR_DONE;
								res_a.string_complete = 1'b1;
								if (variant_q == V_DATA) begin
									text_d = 1'b1;
								end
							end
						end
						rem_d = rem_q - 16'd1;
						if (rem_d == 16'd0) begin
							el_done = 1'b1;
						end
					end
					default: hdr_d = hdr_q;
				endcase
			end
			PH_STOP, PH_REJECT: begin
				phase_d = phase_q;
			end
			default: phase_d = phase_q;
		endcase

		// element end: account payload bytes
		if (el_done) begin
			if (code_d == IE_PAYLOAD && len_d != 16'd0) begin
				add_en  = 1'b1;
				add_val = len_d - 16'd1;
			end else if (code_d == IE_APP_DATA && variant_q == V_DATA) begin
				add_en  = 1'b1;
				add_val = len_d;
			end
			hdr_d = HDR_CODE;
			rem_d = '0;
		end
		if (add_en) begin
			size_sum = {1'b0, size_q} + (SIZE_BITS+1)'(add_val);
			size_d   = size_sum[SIZE_BITS] ? {SIZE_BITS{1'b1}} : size_sum[SIZE_BITS-1:0];
		end

		pos_d = (pos_q != {POSITION_BITS{1'b1}}) ? pos_q + POSITION_BITS'(1) : pos_q;

		// summary word, built from the state after this byte
		res_sum                     = '0;
		res_sum.result_kind         = RK_SUMMARY;
		res_sum.accepted            = (phase_d == PH_ELEMS) || (phase_d == PH_STOP)
						|| (phase_d == PH_DELEMS);
		res_sum.message_type        = type_d;
		res_sum.sent_time           = tacc_d;
		res_sum.disposition         = disp_d;
		res_sum.disposition_present = dseen_d;
		res_sum.notification_type   = notif_d;
		res_sum.payload_size        = size_ext[23:0];
		res_sum.string_complete     = (str_d == STR_DONE);
		res_sum.last                = 1'b1;

		if (last_s1) begin
			pos_d   = '0;
			phase_d = PH_AWAIT;
			code_d  = '0;
			hdr_d   = HDR_CODE;
			len_d   = '0;
			rem_d   = '0;
			str_d   = STR_NONE;
		end
	end

	assign size_ext = {24'd0, size_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_AWAIT;
			variant_q <= V_SDS;
			str_q     <= STR_NONE;
			pos_q     <= '0;
			code_q    <= '0;
			hdr_q     <= HDR_CODE;
			len_q     <= '0;
			rem_q     <= '0;
			tacc_q    <= '0;
			twork_q   <= '0;
			type_q    <= '0;
			disp_q    <= '0;
			dseen_q   <= 1'b0;
			notif_q   <= '0;
			nwork_q   <= '0;
			size_q    <= '0;
			text_q    <= 1'b0;
		end else if (proc) begin
			phase_q   <= phase_d;
			variant_q <= variant_d;
			str_q     <= str_d;
			pos_q     <= pos_d;
			code_q    <= code_d;
			hdr_q     <= hdr_d;
			len_q     <= len_d;
			rem_q     <= rem_d;
			tacc_q    <= tacc_d;
			twork_q   <= twork_d;
			type_q    <= type_d;
			disp_q    <= disp_d;
			dseen_q   <= dseen_d;
			notif_q   <= notif_d;
			nwork_q   <= nwork_d;
			size_q    <= size_d;
			text_q    <= text_d;
		end
	end

	// ---------------- result queue, four words ----------------
	result_t    fifo_q [4];
	logic [1:0] wr_ptr_q, rd_ptr_q, wr_ptr_p1;
	logic [1:0] n_push;
	logic       pop;
	result_t    word0, word1;
	result_t    head;

	assign wr_ptr_p1 = wr_ptr_q + 2'd1;
	assign n_push    = proc ? ({1'b0, emit_a} + {1'b0, last_s1}) : 2'd0;
	assign word0     = emit_a ? res_a : res_sum;
	assign word1     = res_sum;
	assign out_valid = (count_q != 3'd0);
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			fifo_q[wr_ptr_q] <= word0;
		end
		if (n_push == 2'd2) begin
			fifo_q[wr_ptr_p1] <= word1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push;
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			count_q  <= count_q + {1'b0, n_push} - {2'd0, pop};
		end
	end

	assign head                = fifo_q[rd_ptr_q];
	assign result_kind         = head.result_kind;
	assign out_byte            = head.out_byte;
	assign string_is_url       = head.string_is_url;
	assign accepted            = head.accepted;
	assign message_type        = head.message_type;
	assign sent_time           = head.sent_time;
	assign disposition         = head.disposition;
	assign disposition_present = head.disposition_present;
	assign notification_type   = head.notification_type;
	assign payload_size        = head.payload_size;
	assign string_complete     = head.string_complete;
	assign last                = head.last;

	// ---------------- assertions ----------------
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4)
		else $error("result queue overfilled");

	a_id_in_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		proc && emit_a && (res_a.result_kind == RK_CONV || res_a.result_kind == RK_MSG)
		|-> phase_q == PH_FIXED)
		else $error("id byte outside fixed part");

	a_string_variant: assert property (@(posedge clk) disable iff (!arst_n)
		proc && emit_a && res_a.result_kind == RK_STRING
		|-> (variant_q == V_FD || variant_q == V_DATA) && str_q == STR_OPEN)
		else $error("string byte without open string");

	a_summary_clears: assert property (@(posedge clk) disable iff (!arst_n)
		proc && last_s1 |=> phase_q == PH_AWAIT && pos_q == '0 && str_q == STR_NONE)
		else $error("message state not cleared after summary");

	a_room_for_two: assert property (@(posedge clk) disable iff (!arst_n)
		proc |-> count_q <= 3'd2)
		else $error("parse step without room for two words");

endmodule
`default_nettype wire

/* test/sds_message_ie_parser_tb.sv */
// Self-checking testbench for the SDS message element parser.
`timescale 1ns / 100ps

module sds_message_ie_parser_tb;
	import sds_ie_pkg::*;

	localparam int        CYCLE_LIMIT   = 600000;
	localparam int        SETTLE_CYCLES = 8;     // a byte passes through the input register before it reaches the queue
	localparam int        PHASE_QUOTA   = 20;    // walked bytes per type setting
	localparam bit [23:0] POS_FULL      = 24'hFFFFFF;
	localparam bit [23:0] SIZE_FULL     = 24'hFFFFFF;

	// Tracks the parse state of the block byte by byte and holds the result words it must emit.
	class ie_result_board;
		bit [5:0]   type_code [4];
		bit [23:0]  pos;
		phase_t     phase;
		variant_t   var_sel;
		str_state_t str_st;
		bit [7:0]   el_code;
		bit [1:0]   hdr_step;
		bit [15:0]  el_len;
		bit [16:0]  el_left;
		bit [39:0]  time_acc, time_wk;
		bit [5:0]   type_hold;
		bit [3:0]   disp_hold;
		bit         disp_seen;
		bit [7:0]   notif_hold, notif_wk;
		bit [23:0]  size_sum;
		bit         text_done;
		result_t    pending_words [$];
		int         errors, words_checked, walked_bytes, string_words, accepted_msgs;

		function new();
			type_code[CFG_TYPE_SDS]   = 6'd1;
			type_code[CFG_TYPE_FD]    = 6'd2;
			type_code[CFG_TYPE_DATA]  = 6'd3;
			type_code[CFG_TYPE_NOTIF] = 6'd5;
			var_sel = V_SDS;
			clear_message();
		endfunction

		function void clear_message();
			pos = '0;
			phase = PH_AWAIT;
			el_code = '0;
			hdr_step = HDR_CODE;
			el_len = '0;
			el_left = '0;
			str_st = STR_NONE;
		endfunction

		function void set_type(bit [1:0] idx, bit [5:0] v);
			type_code[idx] = v;
		endfunction

		function void add_size(bit [23:0] v);
			if (v > SIZE_FULL - size_sum)
				size_sum = SIZE_FULL;
			else
				size_sum = size_sum + v;
		endfunction

		// payload bytes count only once a length-coded element ends inside the message
		function void close_element();
			if (el_code == IE_PAYLOAD && el_len >= 16'd1)
				add_size({8'h00, el_len - 16'd1});
			else if (el_code == IE_APP_DATA && var_sel == V_DATA)
				add_size({8'h00, el_len});
			hdr_step = HDR_CODE;
			el_left = '0;
		endfunction

		function void note_word(bit [1:0] rk, bit [7:0] b, bit url, bit done);
			result_t w;
			w = '0;
			w.result_kind = rk;
			w.out_byte = b;
			w.string_is_url = url;
			w.string_complete = done;
			pending_words = {pending_words, w};
		endfunction

		// one byte of the optional element walk
		function void walk(bit [7:0] b);
			bit fin;
			case (hdr_step)
			HDR_CODE: begin
				el_code = b;
				el_len = '0;
				if (var_sel == V_DATA)
					hdr_step = HDR_LEN_HI;
				else if ((var_sel == V_SDS && b[7:4] == IE_DISP_SDS) ||
				         (var_sel == V_FD && b[7:4] == IE_DISP_FD)) begin
					disp_hold = b[3:0];
					disp_seen = 1'b1;
				end else if (var_sel == V_FD && b[7:4] == IE_MAND_DL) begin
					// single octet, nothing kept
				end else if (b == IE_FIX16) begin
					el_left = 17'd16;
					hdr_step = HDR_BODY;
				end else if (b == IE_FIX1) begin
					el_left = 17'd1;
					hdr_step = HDR_BODY;
				end else if ((var_sel == V_SDS && b == IE_SDS_TLVE) ||
				             (var_sel == V_FD && (b == IE_PAYLOAD || b == IE_META))) begin
					hdr_step = HDR_LEN_HI;
				end else begin
					phase = PH_STOP;
				end
			end
			HDR_LEN_HI: begin
				el_len = {b, 8'h00};
				hdr_step = HDR_LEN_LO;
			end
			HDR_LEN_LO: begin
				el_len[7:0] = b;
				el_left = {1'b0, el_len};
				if (el_left == 0)
					close_element();
				else
					hdr_step = HDR_BODY;
			end
			default: begin
				if (el_code == IE_PAYLOAD && el_left == {1'b0, el_len}) begin
					// first body byte of a payload names its kind
					if ((var_sel == V_FD && b == PL_FILEURL) ||
					    (var_sel == V_DATA && b == PL_TEXT && !text_done)) begin
						if (el_len == 16'd1)
							str_st = STR_DONE;
						else
							str_st = STR_OPEN;
					end
				end else if (str_st == STR_OPEN) begin
					fin = (el_left == 17'd1);
					if (fin) begin
						str_st = STR_DONE;
						if (var_sel == V_DATA)
							text_done = 1'b1;
					end
					note_word(RK_STRING, b, var_sel == V_FD, fin);
				end
				el_left = el_left - 17'd1;
				if (el_left == 0)
					close_element();
			end
			endcase
		endfunction

		function void take_byte(bit k, bit [7:0] b, bit l);
			int at;
			int offs;
			result_t w;
			at = pos;
			if (phase != PH_STOP && phase != PH_REJECT)
				walked_bytes++;
			if (phase == PH_AWAIT) begin
				type_hold = b[5:0];
				time_wk = '0;
				notif_wk = '0;
				if (!k) begin
					// first match wins: SDS, FD, notification
					phase = PH_FIXED;
					if (type_hold == type_code[CFG_TYPE_SDS])
						var_sel = V_SDS;
					else if (type_hold == type_code[CFG_TYPE_FD])
						var_sel = V_FD;
					else if (type_hold == type_code[CFG_TYPE_NOTIF])
						var_sel = V_NOTIF;
					else
						phase = PH_REJECT;
				end else begin
					var_sel = V_DATA;
					if (type_hold == type_code[CFG_TYPE_DATA])
						phase = PH_DCOUNT;
					else
						phase = PH_REJECT;
				end
			end else if (phase == PH_FIXED) begin
				offs = (var_sel == V_NOTIF) ? 1 : 0;
				if (var_sel == V_NOTIF && at == 1)
					notif_wk = b;
				if (at >= TIME_FIRST + offs && at <= TIME_LAST + offs)
					time_wk = {time_wk[31:0], b};
				if (at >= CONV_FIRST + offs && at <= CONV_LAST + offs)
					note_word(RK_CONV, b, 1'b0, 1'b0);
				else if (at >= MSG_FIRST + offs && at <= MSG_LAST + offs)
					note_word(RK_MSG, b, 1'b0, 1'b0);
				if (at == MSG_LAST + offs) begin
					// fixed part complete: commit time and notification
					time_acc = time_wk;
					if (var_sel == V_NOTIF) begin
						notif_hold = notif_wk;
						phase = PH_STOP;
					end else begin
						phase = PH_ELEMS;
					end
					hdr_step = HDR_CODE;
				end
			end else if (phase == PH_DCOUNT) begin
				phase = PH_DELEMS;
				hdr_step = HDR_CODE;
			end else if (phase == PH_ELEMS || phase == PH_DELEMS) begin
				walk(b);
			end
			if (pos != POS_FULL)
				pos = pos + 24'd1;
			if (l) begin
				w = '0;
				w.result_kind = RK_SUMMARY;
				w.accepted = (phase == PH_ELEMS || phase == PH_STOP || phase == PH_DELEMS);
				w.message_type = type_hold;
				w.sent_time = time_acc;
				w.disposition = disp_hold;
				w.disposition_present = disp_seen;
				w.notification_type = notif_hold;
				w.payload_size = size_sum;
				w.string_complete = (str_st == STR_DONE);
				w.last = 1'b1;
				pending_words = {pending_words, w};
				clear_message();
			end
		endfunction

		function void field_check(string name, logic [39:0] want, logic [39:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void match_word(result_t got);
			result_t want;
			if (pending_words.size() == 0) begin
				$error("result word of kind %0d with nothing expected", got.result_kind);
				errors++;
				return;
			end
			want = pending_words.pop_front();
			words_checked++;
			if (want.result_kind == RK_STRING)
				string_words++;
			if (want.result_kind == RK_SUMMARY && want.accepted)
				accepted_msgs++;
			field_check("result_kind", want.result_kind, got.result_kind);
			field_check("out_byte", want.out_byte, got.out_byte);
			field_check("string_is_url", want.string_is_url, got.string_is_url);
			field_check("accepted", want.accepted, got.accepted);
			field_check("message_type", want.message_type, got.message_type);
			field_check("sent_time", want.sent_time, got.sent_time);
			field_check("disposition", want.disposition, got.disposition);
			field_check("disposition_present", want.disposition_present, got.disposition_present);
			field_check("notification_type", want.notification_type, got.notification_type);
			field_check("payload_size", want.payload_size, got.payload_size);
			field_check("string_complete", want.string_complete, got.string_complete);
			field_check("last", want.last, got.last);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [5:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        kind;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  result_kind;
	logic [7:0]  out_byte;
	logic        string_is_url;
	logic        accepted;
	logic [5:0]  message_type;
	logic [39:0] sent_time;
	logic [3:0]  disposition;
	logic        disposition_present;
	logic [7:0]  notification_type;
	logic [23:0] payload_size;
	logic        string_complete;
	logic        last;

	ie_result_board board;
	result_t        seen_word;
	bit [7:0]       msg_q [$];      // bytes of the message being built
	bit             src_steady;     // sender runs without gaps
	bit             sink_steady;    // receiver runs without stalls
	int             cycle_count;
	int             msgs_sent;
	int             settings_run;

	sds_message_ie_parser dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.kind                (kind),
		.data_byte           (data_byte),
		.last_byte           (last_byte),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.result_kind         (result_kind),
		.out_byte            (out_byte),
		.string_is_url       (string_is_url),
		.accepted            (accepted),
		.message_type        (message_type),
		.sent_time           (sent_time),
		.disposition         (disposition),
		.disposition_present (disposition_present),
		.notification_type   (notification_type),
		.payload_size        (payload_size),
		.string_complete     (string_complete),
		.last                (last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// watchdog
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	// every word taken off the result channel goes to the board
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen_word.result_kind         = result_kind;
			seen_word.out_byte            = out_byte;
			seen_word.string_is_url       = string_is_url;
			seen_word.accepted            = accepted;
			seen_word.message_type        = message_type;
			seen_word.sent_time           = sent_time;
			seen_word.disposition         = disposition;
			seen_word.disposition_present = disposition_present;
			seen_word.notification_type   = notification_type;
			seen_word.payload_size        = payload_size;
			seen_word.string_complete     = string_complete;
			seen_word.last                = last;
			board.match_word(seen_word);
		end
	end

	// Receiver: a random stall before each word, with stretches of no stalls.
	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0)
				sink_steady = !sink_steady;
			stall = sink_steady ? 0 : $urandom_range(0, 14);
			repeat (stall) begin
				@(negedge clk);
				out_ready <= 1'b0;
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// One byte word on the input channel, after a random gap; payload changes on the falling edge.
	task automatic push_byte(bit k, bit [7:0] b, bit l);
		int gap;
		gap = src_steady ? 0 : $urandom_range(0, 14);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid  <= 1'b1;
		kind      <= k;
		data_byte <= b;
		last_byte <= l;
		do @(posedge clk); while (!in_ready);
		board.take_byte(k, b, l);
	endtask

	// Only the kind with the type byte counts; later bytes carry a random kind.
	task automatic send_msg(bit k);
		for (int i = 0; i < msg_q.size(); i++)
			push_byte(i == 0 ? k : 1'($urandom_range(0, 1)), msg_q[i], i == msg_q.size() - 1);
		msgs_sent++;
	endtask

	// Hold the sender until every expected word is out and the pipeline is empty.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_type(bit [1:0] idx, bit [5:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		board.set_type(idx, v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_types(bit [5:0] sds, bit [5:0] fd, bit [5:0] dat, bit [5:0] notif);
		write_type(CFG_TYPE_SDS, sds);
		write_type(CFG_TYPE_FD, fd);
		write_type(CFG_TYPE_DATA, dat);
		write_type(CFG_TYPE_NOTIF, notif);
		settings_run++;
	endtask

	// append one byte to the message being built
	function automatic void add_msg_byte(bit [7:0] b);
		msg_q = {msg_q, b};
	endfunction

	function automatic void put_random(int n);
		repeat (n) add_msg_byte(8'($urandom_range(0, 255)));
	endfunction

	// TLV-E element; the first body byte may be forced to a payload kind
	function automatic void put_tlve(bit [7:0] code, bit [15:0] len, bit [7:0] lead, bit lead_on);
		add_msg_byte(code);
		add_msg_byte(len[15:8]);
		add_msg_byte(len[7:0]);
		for (int i = 0; i < len; i++)
			add_msg_byte((i == 0 && lead_on) ? lead : 8'($urandom_range(0, 255)));
	endfunction

	// type byte (random top bits), optional notification octet, time, both IDs
	function automatic void start_fixed(bit [5:0] code, bit with_notif);
		msg_q.delete();
		add_msg_byte({2'($urandom_range(0, 3)), code});
		put_random(with_notif ? 38 : 37);
	endfunction

	function automatic void start_data(bit [5:0] code);
		msg_q.delete();
		add_msg_byte({2'($urandom_range(0, 3)), code});
		put_random(1);
	endfunction

	function automatic bit [5:0] pick_code(bit [1:0] idx);
		return ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : board.type_code[idx];
	endfunction

	function automatic bit [7:0] lead_byte(bit [7:0] usual);
		return ($urandom_range(0, 3) != 0) ? usual : 8'($urandom_range(0, 255));
	endfunction

	function automatic bit [15:0] elem_len();
		return ($urandom_range(0, 29) == 0) ? 16'($urandom_range(256, 300))
		                                    : 16'($urandom_range(0, 10));
	endfunction

	// Mostly known signalling elements; now and then one that ends the walk.
	function automatic void put_sig_element(bit fd);
		int r;
		r = $urandom_range(0, 19);
		if (r < 3)
			add_msg_byte({fd ? IE_DISP_FD : IE_DISP_SDS, 4'($urandom_range(0, 15))});
		else if (r == 3)
			add_msg_byte({IE_MAND_DL, 4'($urandom_range(0, 15))});
		else if (r < 6) begin
			add_msg_byte(IE_FIX16);
			put_random(16);
		end else if (r < 8) begin
			add_msg_byte(IE_FIX1);
			put_random(1);
		end else if (r < 18) begin
			if (!fd)
				put_tlve(IE_SDS_TLVE, 16'($urandom_range(0, 8)), 8'h00, 1'b0);
			else if ($urandom_range(0, 3) == 0)
				put_tlve(IE_META, 16'($urandom_range(0, 6)), 8'h00, 1'b0);
			else
				put_tlve(IE_PAYLOAD, 16'($urandom_range(0, 10)), lead_byte(PL_FILEURL), 1'b1);
		end else begin
			put_random(1);
		end
	endfunction

	function automatic void put_data_element();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			put_tlve(IE_PAYLOAD, elem_len(), lead_byte(PL_TEXT), 1'b1);
		else if (r < 7)
			put_tlve(IE_APP_DATA, elem_len(), 8'h00, 1'b0);
		else if (r == 7)
			put_tlve(IE_META, elem_len(), 8'h00, 1'b0);
		else
			put_tlve(8'($urandom_range(0, 255)), elem_len(), 8'h00, 1'b0);
	endfunction

	// Mostly well-formed messages with random content; some noise and cut-off messages.
	task automatic random_message();
		int pick;
		int keep;
		bit k;
		pick = $urandom_range(0, 19);
		k = 1'b0;
		if (pick < 6) begin
			start_fixed(pick_code(CFG_TYPE_SDS), 1'b0);
			repeat ($urandom_range(0, 6)) put_sig_element(1'b0);
		end else if (pick < 10) begin
			start_fixed(pick_code(CFG_TYPE_FD), 1'b0);
			repeat ($urandom_range(0, 6)) put_sig_element(1'b1);
		end else if (pick < 12) begin
			start_fixed(pick_code(CFG_TYPE_NOTIF), 1'b1);
			put_random($urandom_range(0, 3));
		end else if (pick < 18) begin
			start_data(pick_code(CFG_TYPE_DATA));
			k = 1'b1;
			repeat ($urandom_range(0, 5)) put_data_element();
		end else begin
			msg_q.delete();
			put_random($urandom_range(1, 8));
			k = 1'($urandom_range(0, 1));
		end
		if ($urandom_range(0, 5) == 0) begin
			keep = $urandom_range(1, msg_q.size());
			while (msg_q.size() > keep)
				void'(msg_q.pop_back());
		end
		if ($urandom_range(0, 4) == 0)
			src_steady = !src_steady;
		send_msg(k);
	endtask

	task automatic random_phase(int quota);
		int goal;
		int since_pause;
		goal = board.walked_bytes + quota;
		since_pause = 0;
		while (board.walked_bytes < goal) begin
			random_message();
			since_pause++;
			if (since_pause >= 6 && $urandom_range(0, 3) == 0) begin
				settle();
				since_pause = 0;
			end
		end
		settle();
	endtask

	initial begin
		board       = new();
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = CFG_TYPE_SDS;
		cfg_data    = '0;
		in_valid    = 1'b0;
		kind        = 1'b0;
		data_byte   = '0;
		last_byte   = 1'b0;
		src_steady  = 1'b0;
		sink_steady = 1'b0;
		cycle_count = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// --- directed part, reset type codes ---
		// lone type byte that matches nothing
		msg_q.delete();
		add_msg_byte(8'hFF);
		send_msg(1'b0);
		// lone data type byte: known type but no count byte, so not accepted
		msg_q.delete();
		add_msg_byte(8'hC3);
		send_msg(1'b1);
		// SDS at the minimum length with extreme field values
		msg_q.delete();
		add_msg_byte(8'hC1);
		repeat (5) add_msg_byte(8'hFF);
		repeat (16) add_msg_byte(8'h00);
		repeat (16) add_msg_byte(8'hFF);
		send_msg(1'b0);
		// SDS with every signalling element, then an unknown one ends the walk
		start_fixed(6'd1, 1'b0);
		add_msg_byte({IE_DISP_SDS, 4'hA});
		add_msg_byte(IE_FIX16);
		put_random(16);
		add_msg_byte(IE_FIX1);
		put_random(1);
		put_tlve(IE_SDS_TLVE, 16'd3, 8'h00, 1'b0);
		add_msg_byte({IE_DISP_SDS, 4'hF});
		add_msg_byte(8'h55);
		put_random(4);
		send_msg(1'b0);
		// FD: disposition, mandatory download, URLs (full, empty, cut off), zero-length and non-URL payloads
		start_fixed(6'd2, 1'b0);
		add_msg_byte({IE_DISP_FD, 4'h0});
		add_msg_byte({IE_MAND_DL, 4'h7});
		put_tlve(IE_PAYLOAD, 16'd5, PL_FILEURL, 1'b1);
		put_tlve(IE_META, 16'd2, 8'h00, 1'b0);
		put_tlve(IE_PAYLOAD, 16'd1, PL_FILEURL, 1'b1);
		put_tlve(IE_PAYLOAD, 16'd0, 8'h00, 1'b0);
		put_tlve(IE_PAYLOAD, 16'd4, PL_TEXT, 1'b1);
		put_tlve(IE_PAYLOAD, 16'd12, PL_FILEURL, 1'b1);
		repeat (5) void'(msg_q.pop_back());
		send_msg(1'b0);
		// SDS disposition code is unknown on the FD side
		start_fixed(6'd2, 1'b0);
		add_msg_byte({IE_DISP_SDS, 4'h5});
		put_random(3);
		send_msg(1'b0);
		// notification with trailing bytes, then one a byte short
		start_fixed(6'd5, 1'b1);
		put_random(3);
		send_msg(1'b0);
		start_fixed(6'd5, 1'b1);
		void'(msg_q.pop_back());
		send_msg(1'b0);
		// short SDS: some conversation bytes come out, time is not committed
		start_fixed(6'd1, 1'b0);
		while (msg_q.size() > 20)
			void'(msg_q.pop_back());
		send_msg(1'b0);
		// data: empty text, app data, unknown skipped, empty app data, huge element cut off
		start_data(6'd3);
		put_tlve(IE_PAYLOAD, 16'd1, PL_TEXT, 1'b1);
		put_tlve(IE_APP_DATA, 16'd3, 8'h00, 1'b0);
		put_tlve(8'hEE, 16'd2, 8'h00, 1'b0);
		put_tlve(IE_APP_DATA, 16'd0, 8'h00, 1'b0);
		put_tlve(IE_APP_DATA, 16'hFFFF, 8'h00, 1'b0);
		while (msg_q.size() > 22)
			void'(msg_q.pop_back());
		send_msg(1'b1);
		// text cut off by the end of the message does not use up the text slot
		start_data(6'd3);
		put_tlve(IE_PAYLOAD, 16'd8, PL_TEXT, 1'b1);
		repeat (3) void'(msg_q.pop_back());
		send_msg(1'b1);
		// full text, long app data, and a second text that must stay silent
		start_data(6'd3);
		put_tlve(IE_PAYLOAD, 16'd6, PL_TEXT, 1'b1);
		put_tlve(IE_APP_DATA, 16'd260, 8'h00, 1'b0);
		put_tlve(IE_PAYLOAD, 16'd4, PL_TEXT, 1'b1);
		send_msg(1'b1);
		// wrong data type; data type code on the signalling side
		start_data(6'd9);
		send_msg(1'b1);
		start_data(6'd3);
		send_msg(1'b0);
		settle();

		// --- random part over several type settings ---
		random_phase(PHASE_QUOTA);
		set_types(6'd0, 6'd0, 6'd0, 6'd0);       // all equal: SDS always wins
		random_phase(PHASE_QUOTA);
		set_types(6'd63, 6'd63, 6'd63, 6'd63);
		random_phase(PHASE_QUOTA);
		set_types(6'd12, 6'd12, 6'd33, 6'd12);   // SDS shadows FD and notification
		random_phase(PHASE_QUOTA);
		set_types(6'd40, 6'd17, 6'd62, 6'd17);   // FD shadows notification
		random_phase(PHASE_QUOTA);
		set_types(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
		          6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
		random_phase(PHASE_QUOTA);

		$display("Ran %0d messages (%0d bytes parsed) over reset codes and %0d type settings.",
		         msgs_sent, board.walked_bytes, settings_run);
		$display("Compared %0d result words: %0d string bytes, %0d accepted summaries.",
		         board.words_checked, board.string_words, board.accepted_msgs);
		if (board.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
